// File: design/mtf_pkg.sv
// shared types and constants of the move-to-front encoder
package mtf_pkg;

    localparam int SYMBOL_W   = 5;
    localparam int POSITION_W = 6;

    // controller to datapath
    typedef struct packed {
        logic start;     // capture request, read list head
        logic step;      // consume one list entry of the scan
        logic load_out;  // move result into output register
    } mtf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hit;       // current entry holds the requested symbol
        logic last;      // current entry is the tail of the list
        logic bad;       // symbol outside the alphabet
        logic out_full;  // output register still holds a result
    } mtf_status_t;

endpackage

// File: design/mtf_ctrl.sv
// control state machine of the move-to-front encoder
module mtf_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 out_ready,
    input  mtf_pkg::mtf_status_t status,
    output mtf_pkg::mtf_cmd_t    cmd
);
    import mtf_pkg::*;

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_ready_reg;
    logic   in_ready_next;

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid && in_ready_reg)
                begin
                    cmd.start  = 1'b1;
                    state_next = SCAN;
                end
            end
            SCAN:
            begin
                if (status.bad)
                begin
                    state_next = DONE;
                end
                else
                begin
                    cmd.step = 1'b1;
                    if (status.hit || status.last)
                    begin
                        state_next = DONE;
                    end
                end
            end
            DONE:
            begin
                // wait for a free output slot
                if (!status.out_full || out_ready)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
        in_ready_next = (state_next == IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            in_ready_reg <= 1'b1;
        end
        else
        begin
            state_reg    <= state_next;
            in_ready_reg <= in_ready_next;
        end
    end

    assign in_ready = in_ready_reg;

endmodule

// File: design/mtf_datapath.sv
// symbol list memory, scan registers and output register
module mtf_datapath #(
    parameter int ALPHABET_SIZE = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [mtf_pkg::SYMBOL_W-1:0]     symbol,
    input  logic                             out_ready,
    output logic                             out_valid,
    output logic [mtf_pkg::POSITION_W-1:0]   position,
    input  mtf_pkg::mtf_cmd_t                cmd,
    output mtf_pkg::mtf_status_t             status
);
    import mtf_pkg::*;

    localparam int IDX_W = $clog2(ALPHABET_SIZE);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ALPHABET_SIZE - 1);

    logic [IDX_W-1:0]      list_mem [ALPHABET_SIZE];
    logic [ALPHABET_SIZE-1:0] written_reg;

    logic [SYMBOL_W-1:0]   symbol_reg;
    logic [IDX_W-1:0]      carry_reg;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      rd_data_reg;
    logic                  rd_written_reg;
    logic                  out_valid_reg;
    logic [POSITION_W-1:0] position_reg;

    logic [IDX_W-1:0]      cur;
    logic [IDX_W-1:0]      sym_val;
    logic                  sym_bad;
    logic                  advance;
    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  wr_en;
    logic [IDX_W:0]        place_plus;

    // an entry never written reads as its own index, through its written flag
    assign cur     = rd_written_reg ? rd_data_reg : idx_reg;
    assign sym_val = IDX_W'(symbol_reg);
    assign sym_bad = (32'(symbol_reg) >= ALPHABET_SIZE);

    assign status.hit      = (cur == sym_val);
    assign status.last     = (idx_reg == LAST_IDX);
    assign status.bad      = sym_bad;
    assign status.out_full = out_valid_reg;

    assign wr_en   = cmd.step && !sym_bad;
    assign advance = wr_en && !status.hit && !status.last;
    assign rd_en   = cmd.start || advance;
    assign rd_addr = cmd.start ? '0 : IDX_W'(idx_reg + 1'b1);

    assign place_plus = {1'b0, idx_reg} + 1'b1;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            list_mem[idx_reg] <= carry_reg;
        end
        if (rd_en)
        begin
            rd_data_reg <= list_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[idx_reg] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    // carry holds the entry that moves back one place
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            symbol_reg <= symbol;
            carry_reg  <= IDX_W'(symbol);
            idx_reg    <= '0;
        end
        else if (advance)
        begin
            carry_reg <= cur;
            idx_reg   <= IDX_W'(idx_reg + 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            position_reg <= sym_bad ? '0 : POSITION_W'(place_plus);
        end
    end

    assign out_valid = out_valid_reg;
    assign position  = position_reg;

endmodule

// File: design/move_to_front_encoder_top.sv
// top level of the move-to-front encoder
//
//  channel   signals                        width  direction
//  request   in_valid, in_ready, symbol     5      in
//  result    out_valid, out_ready, position 6      out
//
// a request is handled in order: the capture of the symbol, a walk of the list
// memory one entry per cycle up to the symbol's place, and the load of the
// output register
// reset sets the list to identity order through per-entry written flags
// a result waiting in the output register does not stop the next request
// from being scanned; only the final load waits for the slot
module move_to_front_encoder_top #(
    parameter int ALPHABET_SIZE = 32
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [mtf_pkg::SYMBOL_W-1:0]   symbol,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mtf_pkg::POSITION_W-1:0] position
);
    import mtf_pkg::*;

    mtf_cmd_t    cmd;
    mtf_status_t status;

    mtf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    mtf_datapath #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .symbol    (symbol),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .position  (position),
        .cmd       (cmd),
        .status    (status)
    );

endmodule
